FILE: src/bsf_pkg.sv
// ----------------------------------------------------------------------------
// Bit stuffing framer package
// Shared types and constants for the framer's sequencer and output stage.
// ----------------------------------------------------------------------------
package bsf_pkg;

  localparam int FLAG_BITS = 8;
  localparam int IDX_W     = $clog2(FLAG_BITS);

  // Flag 01111110, bit k is the k-th bit sent on the line.
  localparam logic [FLAG_BITS-1:0] FLAG_PATTERN = 8'h7E;

  localparam logic [2:0] RUN_LIMIT = 3'd5;

  localparam int          CFG_W             = 5;
  localparam logic [4:0]  CFG_BYTES_DEFAULT = 5'd5;
  localparam logic [4:0]  CFG_BYTES_MIN     = 5'd1;
  localparam logic [4:0]  CFG_BYTES_MAX     = 5'd16;

  // One line bit with its markers.
  typedef struct packed {
    logic line_bit;
    logic is_flag_bit;
    logic is_stuffed_bit;
    logic run_last;
  } bsf_result_t;

endpackage

FILE: src/bit_stuffing_framer_top.sv
// ----------------------------------------------------------------------------
// Bit stuffing framer
// Frames a serial payload stream with HDLC flags and continuous bit stuffing.
// ----------------------------------------------------------------------------
// Each input transaction carries one payload bit; tlast marks the final bit
// of the stream. The block sends one line bit per output transaction: an
// opening flag 01111110 when no frame is open, the payload bit, a stuffed
// zero after five consecutive ones, and a closing flag once the frame holds
// frame_payload_bytes*8 bits (the value is clamped to 1..16, reset 5) or
// the stream ends. One input item therefore gives 1 to 18 line bits, sent
// one per cycle through the single-bit output register unless the output
// stalls, with no gap between items. A following item is accepted in the
// cycle the current item sends its last bit, and output tlast marks that last
// bit. Output tuser[0] flags flag bits, tuser[1] stuffed zeros. Write the
// register only while the block is idle.
module bit_stuffing_framer_top import bsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,   // frame_payload_bytes
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // [0] data_bit, [7:1] zero
  input  logic             s_axis_tlast,  // stream_end
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // [0] line_bit, [7:1] zero
  output logic [1:0]       m_axis_tuser,  // [0] is_flag_bit, [1] is_stuffed_bit
  output logic             m_axis_tlast   // run_last
);

  logic [CFG_W-1:0] frame_payload_bytes;
  logic             res_valid;
  logic             res_ready;
  bsf_result_t      res;
  bsf_result_t      out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_payload_bytes <= CFG_BYTES_DEFAULT;
    end else if (cfg_wr_en) begin
      frame_payload_bytes <= cfg_wr_data;
    end
  end

  bsf_seq u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .frame_payload_bytes (frame_payload_bytes),
    .in_valid            (s_axis_tvalid),
    .in_ready            (s_axis_tready),
    .in_bit              (s_axis_tdata[0]),
    .in_end              (s_axis_tlast),
    .res_valid           (res_valid),
    .res_ready           (res_ready),
    .res                 (res)
  );

  bsf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {7'b0, out_res.line_bit};
  assign m_axis_tuser = {out_res.is_stuffed_bit, out_res.is_flag_bit};
  assign m_axis_tlast = out_res.run_last;

endmodule

FILE: src/bsf_seq.sv
// ----------------------------------------------------------------------------
// Bit stuffing framer sequencer
// Holds one input item and steps it out as flag, data, stuffed and flag bits.
// ----------------------------------------------------------------------------
module bsf_seq import bsf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] frame_payload_bytes,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_bit,
  input  logic             in_end,
  output logic             res_valid,
  input  logic             res_ready,
  output bsf_result_t      res
);

  typedef enum logic [1:0] {
    PH_OPEN,
    PH_DATA,
    PH_STUFF,
    PH_CLOSE
  } phase_t;

  logic             cur_valid, cur_valid_next;
  logic             cur_bit, cur_bit_next;
  logic             cur_end, cur_end_next;
  phase_t           phase, phase_next;
  logic [IDX_W-1:0] flag_idx, flag_idx_next;
  logic [2:0]       ones_run, ones_run_next;
  logic [7:0]       bits_in_frame, bits_in_frame_next;
  logic             frame_open, frame_open_next;
  logic             close_pending, close_pending_next;

  logic [4:0] bytes_clamped;
  logic [7:0] limit_bits;
  logic [2:0] ones_inc;
  logic [7:0] bits_inc;
  logic       stuff_now;
  logic       close_now;
  logic       flag_end;
  logic       emit;
  logic       item_done;

  always_comb begin
    if (frame_payload_bytes < CFG_BYTES_MIN) begin
      bytes_clamped = CFG_BYTES_MIN;
    end else if (frame_payload_bytes > CFG_BYTES_MAX) begin
      bytes_clamped = CFG_BYTES_MAX;
    end else begin
      bytes_clamped = frame_payload_bytes;
    end
  end

  assign limit_bits = {bytes_clamped, 3'b000};
  assign ones_inc   = ones_run + 3'd1;
  assign bits_inc   = (bits_in_frame == 8'hFF) ? bits_in_frame : bits_in_frame + 8'd1;
  assign stuff_now  = cur_bit && (ones_inc >= RUN_LIMIT);
  assign close_now  = cur_end || (bits_inc >= limit_bits);
  assign flag_end   = (flag_idx == IDX_W'(FLAG_BITS - 1));

  always_comb begin
    res = '0;
    case (phase)
      PH_OPEN: begin
        res.line_bit    = FLAG_PATTERN[flag_idx];
        res.is_flag_bit = 1'b1;
      end
      PH_DATA: begin
        res.line_bit = cur_bit;
        res.run_last = !stuff_now && !close_now;
      end
      PH_STUFF: begin
        res.is_stuffed_bit = 1'b1;
        res.run_last       = !close_pending;
      end
      PH_CLOSE: begin
        res.line_bit    = FLAG_PATTERN[flag_idx];
        res.is_flag_bit = 1'b1;
        res.run_last    = flag_end;
      end
      default: res = '0;
    endcase
  end

  assign res_valid = cur_valid;
  assign emit      = cur_valid && res_ready;
  assign item_done = emit && res.run_last;
  // A new item can be taken in the cycle the current one sends its last bit.
  assign in_ready  = !cur_valid || item_done;

  always_comb begin
    cur_valid_next     = cur_valid;
    cur_bit_next       = cur_bit;
    cur_end_next       = cur_end;
    phase_next         = phase;
    flag_idx_next      = flag_idx;
    ones_run_next      = ones_run;
    bits_in_frame_next = bits_in_frame;
    frame_open_next    = frame_open;
    close_pending_next = close_pending;

    if (emit) begin
      case (phase)
        PH_OPEN: begin
          if (flag_end) begin
            flag_idx_next      = '0;
            frame_open_next    = 1'b1;
            ones_run_next      = '0;
            bits_in_frame_next = '0;
            phase_next         = PH_DATA;
          end else begin
            flag_idx_next = flag_idx + IDX_W'(1);
          end
        end
        PH_DATA: begin
          if (stuff_now || !cur_bit) begin
            ones_run_next = '0;
          end else begin
            ones_run_next = ones_inc;
          end
          bits_in_frame_next = bits_inc;
          close_pending_next = close_now;
          flag_idx_next      = '0;
          if (stuff_now) begin
            phase_next = PH_STUFF;
          end else if (close_now) begin
            phase_next = PH_CLOSE;
          end
        end
        PH_STUFF: begin
          if (close_pending) begin
            phase_next = PH_CLOSE;
          end
        end
        PH_CLOSE: begin
          if (flag_end) begin
            flag_idx_next      = '0;
            frame_open_next    = 1'b0;
            ones_run_next      = '0;
            bits_in_frame_next = '0;
          end else begin
            flag_idx_next = flag_idx + IDX_W'(1);
          end
        end
        default: phase_next = PH_OPEN;
      endcase
    end

    if (in_valid && in_ready) begin
      cur_valid_next = 1'b1;
      cur_bit_next   = in_bit;
      cur_end_next   = in_end;
      flag_idx_next  = '0;
      phase_next     = frame_open_next ? PH_DATA : PH_OPEN;
    end else if (item_done) begin
      cur_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      phase         <= PH_OPEN;
      flag_idx      <= '0;
      ones_run      <= '0;
      bits_in_frame <= '0;
      frame_open    <= 1'b0;
      close_pending <= 1'b0;
    end else begin
      cur_valid     <= cur_valid_next;
      phase         <= phase_next;
      flag_idx      <= flag_idx_next;
      ones_run      <= ones_run_next;
      bits_in_frame <= bits_in_frame_next;
      frame_open    <= frame_open_next;
      close_pending <= close_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_bit <= cur_bit_next;
    cur_end <= cur_end_next;
  end

endmodule

FILE: src/bsf_out_reg.sv
// ----------------------------------------------------------------------------
// Bit stuffing framer output register
// Registers one line bit and holds it until the downstream side takes it.
// ----------------------------------------------------------------------------
module bsf_out_reg import bsf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  bsf_result_t in_res,
  output logic        out_valid,
  input  logic        out_ready,
  output bsf_result_t out_res
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_res <= in_res;
    end
  end

endmodule

FILE: src/bsf_checker.sv
// ----------------------------------------------------------------------------
// Bit stuffing framer checker
// Port-level assertions on the framer's line output, bound to the top level.
// ----------------------------------------------------------------------------
module bsf_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic       in_fire;
  logic       out_fire;
  logic [2:0] ones_cnt;
  logic [1:0] pending;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // Consecutive payload ones seen on the line since the last zero or flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      ones_cnt <= '0;
    end else if (out_fire) begin
      if (m_axis_tuser[0] || !m_axis_tdata[0]) begin
        ones_cnt <= '0;
      end else if (ones_cnt != 3'd7) begin
        ones_cnt <= ones_cnt + 3'd1;
      end
    end
  end

  // Input items whose last line bit has not been taken yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_fire && !(out_fire && m_axis_tlast)) begin
      pending <= pending + 2'd1;
    end else if (!in_fire && out_fire && m_axis_tlast) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("line output changed while stalled");

  a_no_six_ones: assert property (@(posedge clk) disable iff (rst)
    out_fire && !m_axis_tuser[0] && m_axis_tdata[0] |-> ones_cnt < 3'd5)
    else $error("six payload ones sent without a stuffed zero");

  a_stuff_after_five: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_axis_tuser[1] |-> ones_cnt == 3'd5 && !m_axis_tdata[0])
    else $error("stuffed zero not preceded by five ones");

  a_last_has_item: assert property (@(posedge clk) disable iff (rst)
    out_fire && m_axis_tlast |-> pending != 2'd0)
    else $error("end of item marked with no item in flight");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("more than two items in flight");

endmodule

bind bit_stuffing_framer_top bsf_checker u_bsf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bit stuffing framer testbench
// Feeds payload bit streams through the framer and checks every line bit,
// along with its flag, stuffed-zero and last-of-item markers, against a
// cycle-free model of HDLC framing with continuous stuffing. The frame length
// register is changed between bursts, including clamped and mid-frame values.
// ----------------------------------------------------------------------------
module tb;
  import bsf_pkg::*;

  localparam int STALL_LIMIT = 500;

  typedef struct packed {
    logic data_bit;
    logic stream_end;
  } payload_item_t;

  logic             clk           = 1'b0;
  logic             rst           = 1'b1;
  logic             cfg_wr_en     = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data   = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata  = '0;
  logic             s_axis_tlast  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic [1:0]       m_axis_tuser;
  logic             m_axis_tlast;

  bit_stuffing_framer_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  payload_item_t payload_q[$];
  bsf_result_t   line_bits_expected[$];

  // Framer state as the testbench sees it.
  logic [4:0] frame_bytes;
  logic [2:0] ones_run;
  logic [7:0] bits_in_frame;
  logic       frame_open;

  bit          gaps_on = 1'b1;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned stall_cycles;
  int unsigned mismatches;
  int unsigned bits_sent;
  int unsigned lines_checked;
  int unsigned stuffed_seen;
  int unsigned settings_used;
  payload_item_t next_item;
  bsf_result_t   want;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bsf_result_t line_result(logic b, logic flag, logic stuffed);
    line_result = {b, flag, stuffed, 1'b0};
  endfunction

  // Line bits that one payload bit produces, appended to the expected queue.
  task automatic frame_payload_bit(input logic data, input logic stream_end);
    bsf_result_t burst[$];
    int unsigned limit_bits;
    limit_bits = {27'd0, frame_bytes};
    if (limit_bits < CFG_BYTES_MIN) limit_bits = {27'd0, CFG_BYTES_MIN};
    if (limit_bits > CFG_BYTES_MAX) limit_bits = {27'd0, CFG_BYTES_MAX};
    limit_bits = limit_bits * FLAG_BITS;
    if (!frame_open) begin
      for (int k = 0; k < FLAG_BITS; k++) burst.push_back(line_result(FLAG_PATTERN[k], 1'b1, 1'b0));
      frame_open    = 1'b1;
      ones_run      = '0;
      bits_in_frame = '0;
    end
    burst.push_back(line_result(data, 1'b0, 1'b0));
    if (data) begin
      ones_run = ones_run + 3'd1;
      if (ones_run >= RUN_LIMIT) begin
        burst.push_back(line_result(1'b0, 1'b0, 1'b1));
        ones_run = '0;
      end
    end else begin
      ones_run = '0;
    end
    if (bits_in_frame != 8'hFF) bits_in_frame = bits_in_frame + 8'd1;
    if (stream_end || bits_in_frame >= limit_bits) begin
      for (int k = 0; k < FLAG_BITS; k++) burst.push_back(line_result(FLAG_PATTERN[k], 1'b1, 1'b0));
      frame_open    = 1'b0;
      ones_run      = '0;
      bits_in_frame = '0;
    end
    burst[burst.size()-1].run_last = 1'b1;
    foreach (burst[i]) line_bits_expected.push_back(burst[i]);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("line bit %0d: %s", lines_checked, what);
  endtask

  // Input driver. The expectation is computed at the edge that takes the item.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap      = 0;
      frame_bytes   = CFG_BYTES_DEFAULT;
      ones_run      = '0;
      bits_in_frame = '0;
      frame_open    = 1'b0;
    end else begin
      if (cfg_wr_en) frame_bytes = cfg_wr_data;
      if (s_axis_tvalid && s_axis_tready) begin
        frame_payload_bit(s_axis_tdata[0], s_axis_tlast);
        bits_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0 || payload_q.size() == 0) begin
          s_axis_tvalid <= 1'b0;
          if (send_gap != 0) send_gap--;
        end else begin
          next_item = payload_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, next_item.data_bit};
          s_axis_tlast  <= next_item.stream_end;
          send_gap      = pick_gap();
        end
      end
    end
  end

  // Output monitor with random backpressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_gap     = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (line_bits_expected.size() == 0) begin
          report_mismatch("line bit arrived with nothing expected");
        end else begin
          want = line_bits_expected.pop_front();
          if (m_axis_tdata !== {7'b0, want.line_bit})
            report_mismatch($sformatf("tdata %h, expected line bit %b", m_axis_tdata, want.line_bit));
          if (m_axis_tuser[0] !== want.is_flag_bit)
            report_mismatch($sformatf("flag marker %b, expected %b", m_axis_tuser[0], want.is_flag_bit));
          if (m_axis_tuser[1] !== want.is_stuffed_bit)
            report_mismatch($sformatf("stuffed marker %b, expected %b", m_axis_tuser[1],
                                      want.is_stuffed_bit));
          if (m_axis_tlast !== want.run_last)
            report_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast, want.run_last));
        end
        if (m_axis_tuser[1] === 1'b1) stuffed_seen++;
        lines_checked++;
      end
      if (ready_gap != 0) begin
        ready_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        ready_gap = pick_gap();
      end
    end
  end

  // Ends the run when neither side has moved a transaction for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d line bits still expected",
               stall_cycles, line_bits_expected.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Sends bits[0] first.
  task automatic queue_bits(input logic [15:0] bits, input int n, input logic end_on_last);
    payload_item_t it;
    for (int i = 0; i < n; i++) begin
      it.data_bit   = bits[i];
      it.stream_end = end_on_last && (i == n - 1);
      payload_q.push_back(it);
    end
  endtask

  task automatic queue_random_stream(input int n);
    payload_item_t it;
    int unsigned   ones_pct;
    ones_pct = $urandom_range(0, 1) ? 85 : 50;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) ones_pct = (ones_pct == 85) ? 50 : 85;
      it.data_bit   = ($urandom_range(0, 99) < ones_pct);
      it.stream_end = ($urandom_range(0, 19) == 0);
      payload_q.push_back(it);
    end
  endtask

  // The sender holds off until every line bit of the queued items has come.
  task automatic wait_drained();
    do @(negedge clk);
    while (payload_q.size() != 0 || s_axis_tvalid || line_bits_expected.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_frame_bytes(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  initial begin
    logic [CFG_W-1:0] random_settings[7];
    random_settings = '{5'd1, 5'd31, 5'd0, 5'd16, 5'd2, 5'd0, 5'd0};
    random_settings[5] = CFG_W'($urandom_range(0, 31));
    random_settings[6] = CFG_W'($urandom_range(1, 16));
    settings_used = 1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Default length: ten ones stuff twice in one run, then a short frame
    // closed by stream end, then a frame of a single bit.
    queue_bits(16'b0000_0011_1111_1111, 11, 1'b1);
    queue_bits(16'b1, 1, 1'b1);
    wait_drained();

    // Zero acts as one byte; the frame fills on five ones, so the stuffed
    // zero goes out ahead of the closing flag.
    write_frame_bytes(5'd0);
    queue_bits(16'b1111_1000, 8, 1'b0);
    wait_drained();

    // Values above the range act as sixteen bytes. The frame is left open,
    // then shrunk below its fill so the next bit closes it.
    write_frame_bytes(5'd17);
    queue_bits(16'b1_0110_1101, 9, 1'b0);
    wait_drained();
    write_frame_bytes(5'd1);
    queue_bits(16'b1, 1, 1'b0);
    wait_drained();

    foreach (random_settings[p]) begin
      write_frame_bytes(random_settings[p]);
      gaps_on = ($urandom_range(0, 3) != 0);
      queue_random_stream($urandom_range(10, 16));
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d payload bits under %0d frame length settings, clamped values included.",
             bits_sent, settings_used);
    $display("Checked %0d line bits, %0d of them stuffed zeros.", lines_checked, stuffed_seen);
    if (mismatches == 0 && line_bits_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: bit_stuffing_framer_top.f
src/bsf_pkg.sv
src/bsf_seq.sv
src/bsf_out_reg.sv
src/bit_stuffing_framer_top.sv
src/bsf_checker.sv
tb/tb.sv
